// File: hdl/deq_pkg.sv
package deq_pkg;

   // Buffer geometry
   localparam int DEPTH = 16;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COUNT_W = $clog2(DEPTH + 1);
   localparam int WORD_W = 32;

   // Operation codes
   localparam logic [1:0] OP_PUSH_FRONT = 2'd0;
   localparam logic [1:0] OP_PUSH_BACK = 2'd1;
   localparam logic [1:0] OP_POP_FRONT = 2'd2;
   localparam logic [1:0] OP_POP_BACK = 2'd3;

   // Status codes
   localparam logic [1:0] ST_OK = 2'd0;
   localparam logic [1:0] ST_EMPTY = 2'd1;
   localparam logic [1:0] ST_FULL = 2'd2;

   // Word returned when nothing is removed
   localparam logic signed [WORD_W-1:0] NONE_VALUE = '1;

   typedef struct packed {
      logic [1:0] operation;
      logic signed [WORD_W-1:0] push_value;
   } req_type;

   typedef struct packed {
      logic signed [WORD_W-1:0] pop_value;
      logic [1:0] status;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic take_req;
      logic load_rsp;
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic out_free;
   } stat_type;

endpackage

// File: hdl/deq_ctrl.sv
module deq_ctrl (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  deq_pkg::stat_type stat,
   output deq_pkg::cmd_type cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESULT = 1'b1;

   logic state_ff;
   logic state_in;

   // Take a request in idle, finish it once the output register can take the result
   always_comb begin
      state_in = state_ff;
      cmd.take_req = 1'b0;
      cmd.load_rsp = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.take_req = req_valid;
            if (req_valid) begin
               state_in = ST_RESULT;
            end
         end
         ST_RESULT: begin
            cmd.load_rsp = stat.out_free;
            if (stat.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: hdl/deq_datapath.sv
module deq_datapath (
   input  logic clock,
   input  logic reset,
   input  deq_pkg::req_type req_payload,
   input  deq_pkg::cmd_type cmd,
   output deq_pkg::stat_type stat,
   output logic rsp_valid,
   input  logic rsp_ready,
   output deq_pkg::rsp_type rsp_payload
);

   logic [deq_pkg::ADDR_W-1:0] front_ff, front_in;
   logic [deq_pkg::ADDR_W-1:0] back_ff, back_in;
   logic [deq_pkg::COUNT_W-1:0] count_ff, count_in;
   logic signed [deq_pkg::WORD_W-1:0] mem [deq_pkg::DEPTH];
   logic signed [deq_pkg::WORD_W-1:0] rd_data_ff;
   logic pend_pop_ff, pend_pop_in;
   logic [1:0] pend_status_ff, pend_status_in;
   deq_pkg::rsp_type rsp_ff, rsp_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic full, empty;
   logic [deq_pkg::ADDR_W-1:0] front_inc, front_dec, back_inc, back_dec;
   logic wr_en, rd_en;
   logic [deq_pkg::ADDR_W-1:0] wr_addr, rd_addr;

   assign full = (count_ff == deq_pkg::COUNT_W'(deq_pkg::DEPTH));
   assign empty = (count_ff == '0);

   // Wrapping pointer neighbors
   assign front_inc = (front_ff == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0
                      : front_ff + 1'b1;
   assign front_dec = (front_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                      : front_ff - 1'b1;
   assign back_inc = (back_ff == deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)) ? '0
                     : back_ff + 1'b1;
   assign back_dec = (back_ff == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                     : back_ff - 1'b1;

   // Decode the request: pointer moves, memory access, pending status
   always_comb begin
      front_in = front_ff;
      back_in = back_ff;
      count_in = count_ff;
      wr_en = 1'b0;
      rd_en = 1'b0;
      wr_addr = front_dec;
      rd_addr = front_ff;
      pend_pop_in = pend_pop_ff;
      pend_status_in = pend_status_ff;
      if (cmd.take_req) begin
         pend_pop_in = 1'b0;
         pend_status_in = deq_pkg::ST_OK;
         unique case (req_payload.operation)
            deq_pkg::OP_PUSH_FRONT: begin
               if (full) begin
                  pend_status_in = deq_pkg::ST_FULL;
               end else begin
                  front_in = front_dec;
                  wr_en = 1'b1;
                  wr_addr = front_dec;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_PUSH_BACK: begin
               if (full) begin
                  pend_status_in = deq_pkg::ST_FULL;
               end else begin
                  back_in = back_inc;
                  wr_en = 1'b1;
                  wr_addr = back_ff;
                  count_in = count_ff + 1'b1;
               end
            end
            deq_pkg::OP_POP_FRONT: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  front_in = front_inc;
                  rd_en = 1'b1;
                  rd_addr = front_ff;
                  pend_pop_in = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            deq_pkg::OP_POP_BACK: begin
               if (empty) begin
                  pend_status_in = deq_pkg::ST_EMPTY;
               end else begin
                  back_in = back_dec;
                  rd_en = 1'b1;
                  rd_addr = back_dec;
                  pend_pop_in = 1'b1;
                  count_in = count_ff - 1'b1;
               end
            end
            default: pend_status_in = deq_pkg::ST_OK;
         endcase
      end
   end

   // Entry memory, registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= req_payload.push_value;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Output register
   assign stat.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.load_rsp) begin
         rsp_in.pop_value = pend_pop_ff ? rd_data_ff : deq_pkg::NONE_VALUE;
         rsp_in.status = pend_status_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      pend_pop_ff <= pend_pop_in;
      pend_status_ff <= pend_status_in;
      rsp_ff <= rsp_in;
      if (reset) begin
         front_ff <= '0;
         back_ff <= '0;
         count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         front_ff <= front_in;
         back_ff <= back_in;
         count_ff <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

// File: hdl/double_ended_queue_unit.sv
// Double-ended queue of signed 32-bit words in a 16-entry circular buffer.
// Request channel (req_valid/req_ready/req_payload): one operation per
// request, push front, push back, pop front or pop back; push_value is used
// by pushes only.
// Response channel (rsp_valid/rsp_ready/rsp_payload): exactly one response
// per request, in order. pop_value carries the removed word of a pop and
// all ones otherwise; status is ok, empty (pop with nothing stored) or
// full (push dropped).
// After a request is accepted, the result state loads its response into the
// output register once that register is free. No new request is taken until
// this load, which follows the registered read of the entry memory, is done.
// A new request is accepted while an earlier response still waits in the
// output register; if the receiver keeps stalling, the next result holds
// in the datapath and req_ready stays low until the output register frees.
// Reset empties the queue (pointers and count to zero) and drops any
// pending response; the entry memory is not cleared.
module double_ended_queue_unit (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_ready,
   input  deq_pkg::req_type req_payload,
   output logic rsp_valid,
   input  logic rsp_ready,
   output deq_pkg::rsp_type rsp_payload
);

   deq_pkg::cmd_type cmd;
   deq_pkg::stat_type stat;

   deq_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .stat(stat),
      .cmd(cmd)
   );

   deq_datapath u_datapath (
      .clock(clock),
      .reset(reset),
      .req_payload(req_payload),
      .cmd(cmd),
      .stat(stat),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   // An accepted request blocks the next one in the following cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request accepted back to back");

   // A result is loaded only when the output register is free
   assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> stat.out_free)
      else $error("result loaded over a waiting response");

   // Non-ok responses carry no word
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_payload.status != deq_pkg::ST_OK))
         |-> (rsp_payload.pop_value == deq_pkg::NONE_VALUE))
      else $error("failed operation returned a word");

   // Status code is never the unused encoding
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status != 2'd3))
      else $error("invalid status code");

endmodule
